// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token kinds and the keyword table of the source tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int NUM_WORDS    = 38;
    localparam int MAX_WORD_LEN = 13;
    localparam int QDEPTH       = 4;
    localparam int QAW          = $clog2(QDEPTH);

    // token kinds
    localparam logic [3:0] K_KEYWORD = 4'd0;
    localparam logic [3:0] K_TYPE    = 4'd1;
    localparam logic [3:0] K_IDENT   = 4'd2;
    localparam logic [3:0] K_INT     = 4'd3;
    localparam logic [3:0] K_FLOAT   = 4'd4;
    localparam logic [3:0] K_OP      = 4'd5;
    localparam logic [3:0] K_STRING  = 4'd6;
    localparam logic [3:0] K_PUNCT   = 4'd7;
    localparam logic [3:0] K_UNKNOWN = 4'd8;

    // one result beat
    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       te;
        logic [3:0] kind;
    } t_res;

    // all beats caused by one input byte (first beat in res[0])
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       res;
    } t_grp;

    // queue status seen by front and back
    typedef struct packed {
        logic           full;
        logic           empty;
    } t_qstat;

    // words holding '_' never match, since identifiers hold only letters and digits
    function automatic logic [127:0] word_text(input int idx);
        case (idx)
            0:  return "func";          1:  return "variable";
            2:  return "array";         3:  return "flex_array";
            4:  return "const";         5:  return "pointer";
            6:  return "referral";      7:  return "object";
            8:  return "class";         9:  return "use";
            10: return "namespace";     11: return "use_scope";
            12: return "switch";        13: return "case";
            14: return "break";         15: return "if";
            16: return "else_if";       17: return "else";
            18: return "for";           19: return "foreach";
            20: return "in";            21: return "while";
            22: return "extends";       23: return "any";
            24: return "create";        25: return "destroy";
            26: return "public";        27: return "private";
            28: return "protected";     29: return "virtual";
            30: return "int";           31: return "string";
            32: return "double";        33: return "float";
            34: return "char";          35: return "void";
            36: return "true";          37: return "false";
            default: return '0;
        endcase
    endfunction

    function automatic logic [3:0] word_len(input int idx);
        logic [127:0] t;
        logic [3:0]   l;
        t = word_text(idx);
        l = 4'd0;
        for (int p = 0; p < 16; p++) begin
            if (t[p*8 +: 8] != 8'd0) begin
                l = 4'(p + 1);
            end
        end
        return l;
    endfunction

    function automatic logic [3:0] word_kind(input int idx);
        return (idx >= 30 && idx <= 35) ? K_TYPE : K_KEYWORD;
    endfunction

    // character at position pos of a table word, zero past its end
    function automatic logic [7:0] word_char(input int idx, input logic [3:0] pos);
        logic [127:0] t;
        int           l;
        t = word_text(idx);
        l = int'(word_len(idx));
        if (int'(pos) < l) begin
            return t[(l - 1 - int'(pos))*8 +: 8];
        end
        return 8'd0;
    endfunction

    // words whose character at pos equals c
    function automatic logic [NUM_WORDS-1:0] char_mask(input logic [7:0] c,
                                                       input logic [3:0] pos);
        logic [NUM_WORDS-1:0] m;
        for (int i = 0; i < NUM_WORDS; i++) begin
            m[i] = (word_char(i, pos) == c);
        end
        return m;
    endfunction

    // first surviving word of matching length decides the kind
    function automatic logic [3:0] cand_kind(input logic [NUM_WORDS-1:0] cand,
                                             input logic [3:0] wlen);
        logic [3:0] k;
        k = K_IDENT;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (cand[i] && word_len(i) == wlen) begin
                k = word_kind(i);
            end
        end
        return k;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]"
            || c == ";" || c == "," || c == "." || c == ":";
    endfunction

endpackage

// ===== hw/rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one byte a cycle while the queue has room, tracks the
// token state and builds the group of result beats that the byte causes.
// ----------------------------------------------------------------------------
module stt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_final,
    input  stt_pkg::t_qstat i_qstat,
    output logic           o_push,
    output stt_pkg::t_grp  o_grp
);
    import stt_pkg::*;

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_SLASH     = 4'd1;
    localparam logic [3:0] M_COMMENT   = 4'd2;
    localparam logic [3:0] M_IDENT     = 4'd3;
    localparam logic [3:0] M_NUMBER    = 4'd4;
    localparam logic [3:0] M_PLUSMINUS = 4'd5;
    localparam logic [3:0] M_BANG      = 4'd6;
    localparam logic [3:0] M_AMP       = 4'd7;
    localparam logic [3:0] M_BAR       = 4'd8;
    localparam logic [3:0] M_EQ1       = 4'd9;
    localparam logic [3:0] M_EQ2       = 4'd10;
    localparam logic [3:0] M_LTGT      = 4'd11;
    localparam logic [3:0] M_STRING    = 4'd12;
    localparam logic [3:0] M_STRESC    = 4'd13;

    logic [3:0]           r_mode,  n_mode;
    logic                 r_dot,   n_dot;
    logic [NUM_WORDS-1:0] r_cand,  n_cand;
    logic [3:0]           r_wlen,  n_wlen;
    logic                 r_minus, n_minus;

    logic       accept;
    logic       do_close;
    logic       do_fresh;
    logic [1:0] cnt;
    t_grp       grp;
    logic [4:0] pk;

    // {valid, kind} of the token left open in a given state
    function automatic logic [4:0] pend_kind(input logic [3:0] mode,
                                             input logic [NUM_WORDS-1:0] cand,
                                             input logic [3:0] wlen,
                                             input logic dot);
        case (mode)
            M_IDENT:     return {1'b1, cand_kind(cand, wlen)};
            M_NUMBER:    return {1'b1, dot ? K_FLOAT : K_INT};
            M_PLUSMINUS, M_BANG, M_AMP, M_EQ1, M_EQ2, M_LTGT:
                         return {1'b1, K_OP};
            M_BAR:       return {1'b1, K_UNKNOWN};
            M_STRING, M_STRESC:
                         return {1'b1, K_STRING};
            default:     return 5'd0;
        endcase
    endfunction

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    // next state and result beats for the byte at the input
    always_comb begin
        n_mode   = r_mode;
        n_dot    = r_dot;
        n_cand   = r_cand;
        n_wlen   = r_wlen;
        n_minus  = r_minus;
        do_close = 1'b0;
        do_fresh = 1'b0;
        cnt      = 2'd0;
        grp      = '0;
        pk       = pend_kind(r_mode, r_cand, r_wlen, r_dot);

        case (r_mode)
            M_COMMENT: begin
                if (i_byte == 8'd10) n_mode = M_IDLE;
            end
            M_SLASH: begin
                if (i_byte == "/") n_mode = M_COMMENT;
                else do_fresh = 1'b1;
            end
            M_IDENT: begin
                if (is_alpha(i_byte) || is_digit(i_byte)) begin
                    n_cand = (r_wlen >= 4'(MAX_WORD_LEN)) ? '0
                           : (r_cand & char_mask(i_byte, r_wlen));
                    n_wlen = (r_wlen == 4'd15) ? r_wlen : r_wlen + 4'd1;
                    grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                    cnt = cnt + 2'd1;
                end else begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(i_byte) || i_byte == ".") begin
                    if (i_byte == ".") n_dot = 1'b1;
                    grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                    cnt = cnt + 2'd1;
                end else begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_PLUSMINUS, M_BANG, M_LTGT, M_AMP, M_BAR, M_EQ1, M_EQ2: begin
                if (r_mode == M_PLUSMINUS && (i_byte == "+" || i_byte == "-")) begin
                    n_minus = 1'b0;
                    grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                    cnt = cnt + 2'd1;
                end else if (r_mode == M_EQ1 && i_byte == "=") begin
                    n_mode = M_EQ2;
                    grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                    cnt = cnt + 2'd1;
                end else if ((r_mode == M_PLUSMINUS && r_minus && i_byte == ">")
                          || ((r_mode == M_BANG || r_mode == M_LTGT || r_mode == M_EQ2)
                              && i_byte == "=")
                          || (r_mode == M_AMP && i_byte == "&")
                          || (r_mode == M_BAR && i_byte == "|")) begin
                    // operator completes on this byte
                    n_mode = M_IDLE;
                    grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                    cnt = cnt + 2'd1;
                    grp.res[cnt] = '{data: 8'd0, bv: 1'b0, te: 1'b1, kind: K_OP};
                    cnt = cnt + 2'd1;
                end else begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            M_STRING: begin
                if (i_byte == "\"") begin
                    n_mode = M_IDLE;
                    grp.res[cnt] = '{data: 8'd0, bv: 1'b0, te: 1'b1, kind: K_STRING};
                    cnt = cnt + 2'd1;
                end else begin
                    if (i_byte == "\\") n_mode = M_STRESC;
                    grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                    cnt = cnt + 2'd1;
                end
            end
            M_STRESC: begin
                n_mode = (i_byte == "\\") ? M_STRESC : M_STRING;
                grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                cnt = cnt + 2'd1;
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        // close the open token
        if (do_close) begin
            n_mode = M_IDLE;
            if (pk[4]) begin
                grp.res[cnt] = '{data: 8'd0, bv: 1'b0, te: 1'b1, kind: pk[3:0]};
                cnt = cnt + 2'd1;
            end
        end

        // classify the byte as the start of a new token
        if (do_fresh) begin
            n_mode = M_IDLE;
            if (is_space(i_byte)) begin
                n_mode = M_IDLE;
            end else if (is_alpha(i_byte)) begin
                n_mode = M_IDENT;
                n_cand = char_mask(i_byte, 4'd0);
                n_wlen = 4'd1;
            end else if (is_digit(i_byte)) begin
                n_mode = M_NUMBER;
                n_dot  = 1'b0;
            end else if (i_byte == "/") begin
                n_mode = M_SLASH;
            end else if (i_byte == "+" || i_byte == "-") begin
                n_mode  = M_PLUSMINUS;
                n_minus = (i_byte == "-");
            end else if (i_byte == "!") begin
                n_mode = M_BANG;
            end else if (i_byte == "&") begin
                n_mode = M_AMP;
            end else if (i_byte == "|") begin
                n_mode = M_BAR;
            end else if (i_byte == "=") begin
                n_mode = M_EQ1;
            end else if (i_byte == "<" || i_byte == ">") begin
                n_mode = M_LTGT;
            end else if (i_byte == "\"") begin
                n_mode = M_STRING;
            end
            if (is_alpha(i_byte) || is_digit(i_byte) || is_punct(i_byte)
                || i_byte == "+" || i_byte == "-" || i_byte == "!" || i_byte == "&"
                || i_byte == "|" || i_byte == "=" || i_byte == "<" || i_byte == ">") begin
                grp.res[cnt] = '{data: i_byte, bv: 1'b1, te: 1'b0, kind: 4'd0};
                cnt = cnt + 2'd1;
            end
            if (is_punct(i_byte)) begin
                grp.res[cnt] = '{data: 8'd0, bv: 1'b0, te: 1'b1, kind: K_PUNCT};
                cnt = cnt + 2'd1;
            end
        end

        // last byte: close whatever is open and return to reset state
        if (i_final) begin
            pk = pend_kind(n_mode, n_cand, n_wlen, n_dot);
            if (pk[4]) begin
                grp.res[cnt] = '{data: 8'd0, bv: 1'b0, te: 1'b1, kind: pk[3:0]};
                cnt = cnt + 2'd1;
            end
            n_mode  = M_IDLE;
            n_dot   = 1'b0;
            n_cand  = '1;
            n_wlen  = 4'd0;
            n_minus = 1'b0;
        end
        grp.cnt = cnt;
    end

    assign o_push = accept && (cnt != 2'd0);
    assign o_grp  = grp;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_dot   <= 1'b0;
            r_cand  <= '1;
            r_wlen  <= 4'd0;
            r_minus <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_dot   <= n_dot;
            r_cand  <= n_cand;
            r_wlen  <= n_wlen;
            r_minus <= n_minus;
        end
    end

endmodule

// ===== hw/rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of result groups between scanner and output serializer.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stt_pkg::t_grp   i_grp,
    input  logic            i_pop,
    output stt_pkg::t_grp   o_head,
    output stt_pkg::t_qstat o_qstat
);
    import stt_pkg::*;

    t_grp             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_count;
    logic             do_push;
    logic             do_pop;

    assign o_qstat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd];

    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_grp;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Serializer: walks the beats of the head group into the output register.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stt_pkg::t_grp   i_head,
    input  stt_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic [5:0]      o_user,
    output logic            o_last
);
    import stt_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic [5:0] r_user;
    logic       r_last;
    logic [1:0] r_idx;
    logic       load;
    logic       at_end;
    t_res       beat;

    assign beat   = i_head.res[r_idx];
    assign at_end = (r_idx == i_head.cnt - 2'd1);
    assign load   = !i_qstat.empty && (!r_valid || i_ready);
    assign o_pop  = load && at_end;

    // beat index inside the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            if (load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= beat.data;
            r_user <= {beat.kind, beat.te, beat.bv};
            r_last <= at_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

// ===== hw/rtl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream tokenizer: token characters out as they arrive, then an end
// beat carrying the token kind.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle on the slave side (tlast on the last byte
// of the source) and sends result beats on the master side. Each input byte
// gives zero to three result beats, one beat per cycle leaves the output
// register while the receiver is ready; a four-group queue between the
// scanner and the serializer absorbs bursts, so input runs at one byte per
// cycle while the output keeps up, and otherwise at the output beat rate.
// A result beat passes through the queue and then the output register. The
// scanner state and keyword mask update once for each accepted byte.
module source_text_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [5:0] m_tuser,   // [0] byte_valid, [1] token_end, [5:2] token_kind
    output logic       m_tlast    // run_last
);
    import stt_pkg::*;

    t_qstat qstat;
    t_grp   grp;
    t_grp   head;
    logic   push;
    logic   pop;

    stt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_byte  (s_tdata),
        .i_final (s_tlast),
        .i_qstat (qstat),
        .o_push  (push),
        .o_grp   (grp)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata),
        .o_user  (m_tuser),
        .o_last  (m_tlast)
    );

`ifndef SYNTHESIS
    // input is held off only when the queue is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> qstat.full)
        else $error("tokenizer stalled input with queue space left");

    // a beat is either a character or an end marker
    a_beat_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot(m_tuser[1:0]))
        else $error("result beat is neither character nor end marker");

    // character beats carry kind zero
    a_char_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[5:2] == 4'd0))
        else $error("character beat with nonzero kind");

    // push never lands on a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("group pushed into full queue");
`endif

endmodule

// ===== tb/sv/source_text_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Self-checking bench: directed token cases, then random token streams, with
// a local scanner model predicting every output beat.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    // one expected output beat
    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       te;
        logic [3:0] kind;
        logic       last;
    } t_beat;

    typedef enum logic [3:0] {
        SM_IDLE, SM_SLASH, SM_COMMENT, SM_IDENT, SM_NUMBER, SM_PLUSMINUS, SM_BANG,
        SM_AMP, SM_BAR, SM_EQ1, SM_EQ2, SM_LTGT, SM_STRING, SM_STRESC
    } t_scan;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] text_byte
    logic       s_tlast;    // final_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic [5:0] m_tuser;    // [0] byte_valid, [1] token_end, [5:2] token_kind
    logic       m_tlast;    // run_last

    source_text_tokenizer dut (.*);

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // word table copy, first entry in the list
    string words [NUM_WORDS] = '{
        "func", "variable", "array", "flex_array", "const", "pointer",
        "referral", "object", "class", "use", "namespace", "use_scope",
        "switch", "case", "break", "if", "else_if", "else", "for", "foreach",
        "in", "while", "extends", "any", "create", "destroy", "public",
        "private", "protected", "virtual", "int", "string", "double", "float",
        "char", "void", "true", "false"};

    // scanner model state
    t_scan                 mode;
    logic                  dot_seen;
    logic [NUM_WORDS-1:0]  cands;
    logic [3:0]            wlen;
    logic                  lone_minus;

    t_beat  expected_beats[$];
    t_beat  step_beats[$];
    int     errors;
    int     burst_left;

    function automatic bit alpha_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit space_c(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic bit punct_c(logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]"
            || c == ";" || c == "," || c == "." || c == ":";
    endfunction

    task automatic push_byte(logic [7:0] c);
        step_beats.insert(step_beats.size(), '{c, 1'b1, 1'b0, K_KEYWORD, 1'b0});
    endtask
    task automatic push_end(logic [3:0] k);
        step_beats.insert(step_beats.size(), '{8'd0, 1'b0, 1'b1, k, 1'b0});
    endtask

    task automatic model_reset();
        mode = SM_IDLE; dot_seen = 0; cands = '1; wlen = 0; lone_minus = 0;
    endtask

    task automatic add_letter(logic [7:0] c);
        if (wlen >= MAX_WORD_LEN) cands = '0;
        else begin
            for (int i = 0; i < NUM_WORDS; i++)
                if (wlen >= words[i].len() || words[i][wlen] != c) cands[i] = 1'b0;
        end
        if (wlen < 15) wlen++;
    endtask

    function automatic logic [3:0] ident_kind();
        for (int i = 0; i < NUM_WORDS; i++)
            if (cands[i] && words[i].len() == wlen)
                return (i >= 30 && i <= 35) ? K_TYPE : K_KEYWORD;
        return K_IDENT;
    endfunction

    task automatic close_token();
        case (mode)
            SM_IDENT:  push_end(ident_kind());
            SM_NUMBER: push_end(dot_seen ? K_FLOAT : K_INT);
            SM_PLUSMINUS, SM_BANG, SM_AMP, SM_EQ1, SM_EQ2, SM_LTGT: push_end(K_OP);
            SM_BAR:    push_end(K_UNKNOWN);
            SM_STRING, SM_STRESC: push_end(K_STRING);
            default: ;
        endcase
        mode = SM_IDLE;
    endtask

    task automatic begin_token(logic [7:0] c);
        mode = SM_IDLE;
        if (space_c(c)) return;
        if (alpha_c(c)) begin
            mode = SM_IDENT; cands = '1; wlen = 0; add_letter(c); push_byte(c);
        end else if (digit_c(c)) begin
            mode = SM_NUMBER; dot_seen = 0; push_byte(c);
        end else if (c == "/") mode = SM_SLASH;
        else if (c == "+" || c == "-") begin
            mode = SM_PLUSMINUS; lone_minus = (c == "-"); push_byte(c);
        end else if (c == "!") begin mode = SM_BANG; push_byte(c); end
        else if (c == "&") begin mode = SM_AMP; push_byte(c); end
        else if (c == "|") begin mode = SM_BAR; push_byte(c); end
        else if (c == "=") begin mode = SM_EQ1; push_byte(c); end
        else if (c == "<" || c == ">") begin mode = SM_LTGT; push_byte(c); end
        else if (c == "\"") mode = SM_STRING;
        else if (punct_c(c)) begin push_byte(c); push_end(K_PUNCT); end
    endtask

    task automatic close_op(logic [7:0] c);
        push_byte(c); push_end(K_OP); mode = SM_IDLE;
    endtask

    // predict the beats of one accepted byte and queue them
    task automatic predict_beats(logic [7:0] c, logic fin);
        step_beats.delete();
        case (mode)
            SM_COMMENT: if (c == 8'h0a) mode = SM_IDLE;
            SM_SLASH: if (c == "/") mode = SM_COMMENT; else begin_token(c);
            SM_IDENT:
                if (alpha_c(c) || digit_c(c)) begin add_letter(c); push_byte(c); end
                else begin close_token(); begin_token(c); end
            SM_NUMBER:
                if (digit_c(c) || c == ".") begin
                    if (c == ".") dot_seen = 1;
                    push_byte(c);
                end else begin close_token(); begin_token(c); end
            SM_PLUSMINUS:
                if (c == "+" || c == "-") begin lone_minus = 0; push_byte(c); end
                else if (lone_minus && c == ">") close_op(c);
                else begin close_token(); begin_token(c); end
            SM_BANG, SM_LTGT, SM_EQ2:
                if (c == "=") close_op(c); else begin close_token(); begin_token(c); end
            SM_AMP: if (c == "&") close_op(c); else begin close_token(); begin_token(c); end
            SM_BAR: if (c == "|") close_op(c); else begin close_token(); begin_token(c); end
            SM_EQ1:
                if (c == "=") begin push_byte(c); mode = SM_EQ2; end
                else begin close_token(); begin_token(c); end
            SM_STRING:
                if (c == "\"") begin push_end(K_STRING); mode = SM_IDLE; end
                else begin push_byte(c); if (c == "\\") mode = SM_STRESC; end
            SM_STRESC: begin
                push_byte(c);
                mode = (c == "\\") ? SM_STRESC : SM_STRING;
            end
            default: begin_token(c);
        endcase
        if (fin) begin close_token(); model_reset(); end
        if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    endtask

    // send one byte; bursts with random gaps between them
    task automatic send_byte(logic [7:0] c, logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1; s_tdata <= c; s_tlast <= fin;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_beats(c, fin);
    endtask

    task automatic send_text(string s, bit fin_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_at_end && i == s.len() - 1);
    endtask

    // receiver stall pattern: runs of ready and not ready
    initial begin
        m_tready = 1'b0;
        forever begin
            int on_len;
            int off_len;
            on_len = $urandom_range(1, 20);
            off_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (on_len) begin m_tready <= 1'b1; @(posedge i_clk); end
            repeat (off_len) begin m_tready <= 1'b0; @(posedge i_clk); end
        end
    end

    // compare every accepted output beat with the oldest expectation
    always @(posedge i_clk) begin
        t_beat exp_b;
        t_beat got_b;
        if (i_rst_n && m_tvalid && m_tready) begin
            got_b = '{m_tdata, m_tuser[0], m_tuser[1], m_tuser[5:2], m_tlast};
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $realtime, got_b);
                errors++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (got_b !== exp_b) begin
                    $display("%0t: beat mismatch, expected data %h bv %b te %b kind %0d last %b,",
                             $realtime, exp_b.data, exp_b.bv, exp_b.te, exp_b.kind, exp_b.last);
                    $display("%0t:   actual data %h bv %b te %b kind %0d last %b",
                             $realtime, got_b.data, got_b.bv, got_b.te, got_b.kind,
                             got_b.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_words();
        send_text("func int string foo flex_array else_if averyveryverylongname ", 0);
        send_text("x9 Void true\n", 1);
    endtask

    task automatic test_numbers_punct();
        send_text("0 123 3.14 9.. (){}[];,.:", 1);
    endtask

    task automatic test_operators();
        send_text("-> --> ++ += = == === ==== <= >= < ! != && & || | ", 0);
        send_text("a/b // note\nz", 1);
    endtask

    task automatic test_strings();
        send_text("\"\" \"ab\\\"c\" \"x\\\\\" \"open", 1);
    endtask

    task automatic test_extremes();
        send_byte(8'h00, 0); send_byte(8'hff, 0); send_byte(8'h80, 0);
        send_byte("q", 1); send_byte(8'h7f, 1);
    endtask

    // random token streams, mostly well formed
    task automatic test_random_streams();
        string frags [18] = '{"func", "int", "x", "abc1", "42", "1.5", "->", "==",
            "===", "!", "!=", "&&", "||", "|", "++", "\"s\\\"t\"", "// c\n", ";"};
        int n;
        n = 0;
        while (n < 20) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                n++;
            end else begin
                string f;
                f = frags[$urandom_range(0, 17)];
                send_text(f, 0);
                n += f.len();
                if ($urandom_range(0, 2) != 0) begin send_byte(" ", 0); n++; end
                if ($urandom_range(0, 12) == 0) begin send_byte(" ", 1); n++; end
            end
        end
        send_byte(" ", 1);
    endtask

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        errors = 0; burst_left = 0;
        model_reset();
        i_rst_n <= 1'b0; s_tvalid <= 1'b0; s_tdata <= 8'd0; s_tlast <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_words();
        test_numbers_punct();
        test_operators();
        test_strings();
        test_extremes();
        test_random_streams();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
